// ===== sv/selt_pkg.sv =====
`default_nettype none

package selt_pkg;

  // table geometry
  localparam int LOCK_SLOTS = 8;
  localparam int CLIENTS    = 16;

  // request kinds
  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_SHARED  = 2'd1;
  localparam logic [1:0] KIND_EXCL    = 2'd2;

  // result codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/selt_ctrl.sv =====
`default_nettype none

module selt_ctrl
  import selt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dp_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        // nothing is taken while reset is held
        if (rst_n) begin
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // an accepted transaction always produces exactly one result slot
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("accepted transaction did not reach the output");

endmodule

`default_nettype wire

// ===== sv/selt_dp.sv =====
`default_nettype none

module selt_dp
  import selt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  input  wire logic [1:0] in_kind,
  input  wire logic [3:0] in_client,
  input  wire logic [2:0] in_first_slot,
  input  wire logic [3:0] in_slot_count,
  output logic [1:0]      out_status
);

  // latched request
  logic [1:0] kind_r;
  logic [3:0] client_r;
  logic [2:0] first_r;
  logic [3:0] count_r;

  // lock state
  logic [LOCK_SLOTS-1:0]      sh_mask_r [CLIENTS];
  logic [LOCK_SLOTS-1:0]      ex_mask_r [CLIENTS];
  logic [LOCK_SLOTS-1:0][4:0] sh_cnt_r;
  logic [LOCK_SLOTS-1:0]      ex_cnt_r;
  logic [1:0]                 status_r;

  logic [LOCK_SLOTS-1:0]      sh_mask_nxt;
  logic [LOCK_SLOTS-1:0]      ex_mask_nxt;
  logic [LOCK_SLOTS-1:0][4:0] sh_cnt_nxt;
  logic [LOCK_SLOTS-1:0]      ex_cnt_nxt;
  logic [1:0]                 status_nxt;

  logic [LOCK_SLOTS-1:0] own_s;
  logic [LOCK_SLOTS-1:0] own_x;
  logic [LOCK_SLOTS-1:0] range_m;
  logic [4:0]            end_slot;
  logic                  req_ok;
  logic                  busy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      client_r <= in_client;
      first_r  <= in_first_slot;
      count_r  <= in_slot_count;
    end
  end

  assign end_slot = {2'b00, first_r} + {1'b0, count_r};
  assign req_ok   = (kind_r inside {KIND_RELEASE, KIND_SHARED, KIND_EXCL})
                    && ({1'b0, client_r} < 5'(CLIENTS))
                    && (count_r != 4'd0)
                    && (end_slot <= 5'(LOCK_SLOTS));
  assign own_s    = sh_mask_r[client_r];
  assign own_x    = ex_mask_r[client_r];

  always_comb begin
    busy        = 1'b0;
    sh_mask_nxt = own_s;
    ex_mask_nxt = own_x;
    sh_cnt_nxt  = sh_cnt_r;
    ex_cnt_nxt  = ex_cnt_r;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      range_m[i] = (5'(i) >= {2'b00, first_r}) && (5'(i) < end_slot);
      if (range_m[i]) begin
        if (kind_r == KIND_SHARED && ex_cnt_r[i] != own_x[i]) begin
          busy = 1'b1;
        end
        if (kind_r == KIND_EXCL &&
            (ex_cnt_r[i] != own_x[i] || sh_cnt_r[i] != {4'd0, own_s[i]})) begin
          busy = 1'b1;
        end
        case (kind_r)
          KIND_RELEASE: begin
            if (own_s[i]) begin
              sh_mask_nxt[i] = 1'b0;
              if (sh_cnt_r[i] != 5'd0) begin
                sh_cnt_nxt[i] = sh_cnt_r[i] - 5'd1;
              end
            end
            if (own_x[i]) begin
              ex_mask_nxt[i] = 1'b0;
              ex_cnt_nxt[i]  = 1'b0;
            end
          end
          KIND_SHARED: begin
            if (!own_s[i]) begin
              sh_mask_nxt[i] = 1'b1;
              sh_cnt_nxt[i]  = sh_cnt_r[i] + 5'd1;
            end
          end
          KIND_EXCL: begin
            if (!own_x[i]) begin
              ex_mask_nxt[i] = 1'b1;
              ex_cnt_nxt[i]  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (!req_ok) begin
      status_nxt = ST_INVALID;
    end else if (busy) begin
      status_nxt = ST_BUSY;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLIENTS; c++) begin
        sh_mask_r[c] <= '0;
        ex_mask_r[c] <= '0;
      end
      sh_cnt_r <= '0;
      ex_cnt_r <= '0;
    end else if (cmd.exec && status_nxt == ST_OK) begin
      sh_mask_r[client_r] <= sh_mask_nxt;
      ex_mask_r[client_r] <= ex_mask_nxt;
      sh_cnt_r            <= sh_cnt_nxt;
      ex_cnt_r            <= ex_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  assign out_status = status_r;

  // a refused or invalid request leaves the slot counts untouched
  a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt != ST_OK) |=> ($stable(sh_cnt_r) && $stable(ex_cnt_r)))
    else $error("refused request changed slot counts");

  // a granted exclusive acquire marks every slot of its range held exclusive
  a_excl_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt == ST_OK && kind_r == KIND_EXCL)
      |=> ((ex_cnt_r & $past(range_m)) == $past(range_m)))
    else $error("exclusive grant did not mark its range");

endmodule

`default_nettype wire

// ===== sv/shared_exclusive_lock_table_top.sv =====
`default_nettype none

// shared/exclusive lock table: eight lock slots shared by sixteen clients. each
// request transaction names a client, a range of consecutive slots and a kind
// (release, acquire shared, acquire exclusive) and returns one status
// transaction: 0 granted or done, 1 busy (refused, nothing changed), 2 invalid
// range, kind or count (nothing changed). requests are handled one at a time:
// a transaction is taken in the idle state, checked and applied in the exec
// state after it, and its status is offered in the out state that follows,
// held there while the output is stalled; the controller accepts the next
// request only once the status has been taken. the whole table is cleared by
// reset and is usable as soon as reset is released.

module shared_exclusive_lock_table_top
  import selt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [3:0] in_client,
  input  wire logic [2:0] in_first_slot,
  input  wire logic [3:0] in_slot_count,
  // status channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status
);

  dp_cmd_t cmd;

  // sequencing: idle, check and update, present status
  selt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // lock state, parallel range check across all slots, status register
  selt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_kind),
    .in_client     (in_client),
    .in_first_slot (in_first_slot),
    .in_slot_count (in_slot_count),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

// ===== tb/sv/lock_grant_tracker.sv =====
module lock_grant_tracker
  import selt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [3:0] in_client,
  input  logic [2:0] in_first_slot,
  input  logic [3:0] in_slot_count,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         status_pending
);

  typedef struct {
    logic [1:0] status;
    logic [1:0] kind;
    logic [3:0] client;
    logic [2:0] first_slot;
    logic [3:0] slot_count;
  } grant_t;

  // per-client holdings and per-slot counts
  logic [LOCK_SLOTS-1:0] held_shared [CLIENTS];
  logic [LOCK_SLOTS-1:0] held_excl   [CLIENTS];
  logic [4:0]            sharers     [LOCK_SLOTS];
  logic                  excl_taken  [LOCK_SLOTS];
  grant_t                grants_due  [$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count <= fail_count + 1;
  endtask

  // works out the status of one request and applies it to the table
  function automatic logic [1:0] grant_status(input logic [1:0] kind,
                                              input logic [3:0] client,
                                              input logic [2:0] first,
                                              input logic [3:0] count);
    logic [LOCK_SLOTS-1:0] span;
    logic [LOCK_SLOTS-1:0] mine_s;
    logic [LOCK_SLOTS-1:0] mine_x;
    int                    stop;
    stop = int'(first) + int'(count);
    if (kind > KIND_EXCL || int'(client) >= CLIENTS || count == 4'd0 || stop > LOCK_SLOTS)
      return ST_INVALID;
    mine_s = held_shared[client];
    mine_x = held_excl[client];
    for (int i = 0; i < LOCK_SLOTS; i++)
      span[i] = (i >= int'(first)) && (i < stop);

    // whole range checked before anything changes
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (span[i]) begin
        if (kind != KIND_RELEASE && excl_taken[i] != mine_x[i])
          return ST_BUSY;
        if (kind == KIND_EXCL && sharers[i] != {4'd0, mine_s[i]})
          return ST_BUSY;
      end
    end

    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (span[i]) begin
        case (kind)
          KIND_RELEASE: begin
            if (mine_s[i]) begin
              mine_s[i] = 1'b0;
              if (sharers[i] != 5'd0)
                sharers[i] = sharers[i] - 5'd1;
            end
            if (mine_x[i]) begin
              mine_x[i]     = 1'b0;
              excl_taken[i] = 1'b0;
            end
          end
          KIND_SHARED: begin
            if (!mine_s[i]) begin
              mine_s[i]  = 1'b1;
              sharers[i] = sharers[i] + 5'd1;
            end
          end
          default: begin
            if (!mine_x[i]) begin
              mine_x[i]     = 1'b1;
              excl_taken[i] = 1'b1;
            end
          end
        endcase
      end
    end
    held_shared[client] = mine_s;
    held_excl[client]   = mine_x;
    return ST_OK;
  endfunction

  always @(posedge clk) begin : track
    grant_t due;
    if (!rst_n) begin
      for (int c = 0; c < CLIENTS; c++) begin
        held_shared[c] = '0;
        held_excl[c]   = '0;
      end
      for (int s = 0; s < LOCK_SLOTS; s++) begin
        sharers[s]    = 5'd0;
        excl_taken[s] = 1'b0;
      end
      grants_due.delete();
      fail_count     <= 0;
      status_pending <= 0;
    end else begin
      // a status transaction always belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          report_mismatch($sformatf("status %0d with no request outstanding", out_status));
        end else begin
          due = grants_due.pop_front();
          if (out_status !== due.status)
            report_mismatch($sformatf(
              "kind %0d client %0d first %0d count %0d: status %0d, predicted %0d",
              due.kind, due.client, due.first_slot, due.slot_count,
              out_status, due.status));
        end
      end
      if (in_valid && !in_stall) begin
        due.kind       = in_kind;
        due.client     = in_client;
        due.first_slot = in_first_slot;
        due.slot_count = in_slot_count;
        due.status     = grant_status(in_kind, in_client, in_first_slot, in_slot_count);
        grants_due.insert(grants_due.size(), due);
      end
      status_pending <= grants_due.size();
    end
  end

endmodule

// ===== tb/sv/shared_exclusive_lock_table_top_tb.sv =====
module shared_exclusive_lock_table_top_tb;
  import selt_pkg::*;

  // a kind the block must reject as invalid
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind       = KIND_RELEASE;
  logic [3:0] in_client     = 4'd0;
  logic [2:0] in_first_slot = 3'd0;
  logic [3:0] in_slot_count = 4'd0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [1:0] out_status;
  // high during a stretch where neither side idles
  logic       calm          = 1'b0;
  int         fail_count;
  int         status_pending;

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shared_exclusive_lock_table_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_client     (in_client),
    .in_first_slot (in_first_slot),
    .in_slot_count (in_slot_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status)
  );

  // watches both channels, predicts each status and compares
  lock_grant_tracker i_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_client      (in_client),
    .in_first_slot  (in_first_slot),
    .in_slot_count  (in_slot_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .fail_count     (fail_count),
    .status_pending (status_pending)
  );

  // status receiver stalls at random with a chance of 7 in a hundred, never in the calm stretch
  always @(posedge clk) begin
    if (!rst_n || calm)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < 7);
  end

  // offers one request transaction and returns at the edge that takes it;
  // valid is only lowered during an idle gap, so back-to-back requests keep it high
  task automatic issue_request(input logic [1:0] kind, input logic [3:0] client,
                               input logic [2:0] first, input logic [3:0] count);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_client     <= client;
    in_first_slot <= first;
    in_slot_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [1:0] kind;
    logic [3:0] client;
    logic [2:0] first;
    logic [3:0] count;
    int         pick;
    int         span_max;

    // synchronous reset held at the start, applied once only
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: releasing locks that are not held is simply done
    issue_request(KIND_RELEASE, 4'd0, 3'd0, 4'd8);
    // two overlapping shared holders
    issue_request(KIND_SHARED, 4'd1, 3'd0, 4'd4);
    issue_request(KIND_SHARED, 4'd2, 3'd2, 4'd4);
    // exclusive over a slot someone else shares is refused
    issue_request(KIND_EXCL, 4'd3, 3'd3, 4'd1);
    // exclusive over slots the client alone shares is granted
    issue_request(KIND_EXCL, 4'd1, 3'd0, 4'd2);
    // shared over another client's exclusive slot is refused
    issue_request(KIND_SHARED, 4'd2, 3'd1, 4'd1);
    // repeat acquires in both modes
    issue_request(KIND_SHARED, 4'd1, 3'd0, 4'd4);
    issue_request(KIND_EXCL, 4'd1, 3'd0, 4'd2);
    // highest client on the last slot, then contention there
    issue_request(KIND_EXCL, 4'd15, 3'd7, 4'd1);
    issue_request(KIND_SHARED, 4'd14, 3'd7, 4'd1);
    issue_request(KIND_RELEASE, 4'd1, 3'd0, 4'd8);
    issue_request(KIND_EXCL, 4'd0, 3'd0, 4'd8);
    issue_request(KIND_RELEASE, 4'd2, 3'd0, 4'd8);
    issue_request(KIND_RELEASE, 4'd15, 3'd7, 4'd1);
    // whole table exclusive once everyone has let go
    issue_request(KIND_EXCL, 4'd0, 3'd0, 4'd8);
    issue_request(KIND_RELEASE, 4'd0, 3'd0, 4'd8);
    // invalid: empty range, range past the end, largest count, unknown kind
    issue_request(KIND_SHARED, 4'd4, 3'd3, 4'd0);
    issue_request(KIND_EXCL, 4'd5, 3'd7, 4'd2);
    issue_request(KIND_SHARED, 4'd6, 3'd7, 4'd15);
    issue_request(KIND_UNKNOWN, 4'd8, 3'd0, 4'd1);
    // whole-table shared, then a partial release
    issue_request(KIND_SHARED, 4'd7, 3'd0, 4'd8);
    issue_request(KIND_RELEASE, 4'd7, 3'd4, 4'd4);
    issue_request(KIND_RELEASE, 4'd7, 3'd0, 4'd8);

    // random: mostly well-formed requests from a small pool of clients so that
    // they contend, with a little noise of any kind and any count
    for (int n = 0; n < 600; n++) begin
      calm <= (n >= 250 && n < 400);
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0)
        client = 4'($urandom_range(15));
      else
        client = 4'($urandom_range(3));
      first    = 3'($urandom_range(7));
      span_max = LOCK_SLOTS - int'(first);
      // short ranges half the time for finer-grained sharing
      if (span_max > 2 && $urandom_range(1) == 0)
        span_max = 2;
      count = 4'($urandom_range(span_max, 1));
      if (pick < 5) begin
        kind  = 2'($urandom_range(3));
        count = 4'($urandom_range(15));
      end else if (pick < 35) begin
        kind = KIND_RELEASE;
      end else if (pick < 68) begin
        kind = KIND_SHARED;
      end else begin
        kind = KIND_EXCL;
      end
      issue_request(kind, client, first, count);
    end
    calm     <= 1'b0;
    in_valid <= 1'b0;

    // drain outstanding status transactions, then a short quiet spell
    @(posedge clk);
    while (status_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
